// ===== src/lbp3_pkg.sv =====
// shared types and constants for the 3x3 local binary pattern stream core
// no dependencies; every other file imports this package
package lbp3_pkg;

   // frame geometry
   localparam int MAX_WIDTH       = 1024;
   localparam int COL_BITS        = $clog2(MAX_WIDTH);
   localparam int ROW_BITS        = 12;
   localparam int HEIGHT_MAX      = 4096;
   localparam int PIX_BITS        = 8;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int WIDTH_RESET     = 640;
   localparam int HEIGHT_RESET    = 480;

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   // input transfer payload
   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_value;
      logic                frame_start;
   } lbp3_req_type;

   // result transfer payload
   typedef struct packed {
      logic [7:0] pattern_code;
      logic       frame_last;
   } lbp3_rsp_type;

   // position information of one accepted pixel
   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic                has_result;
      logic                last;
   } lbp3_scan_type;

   // one line store entry: row two above and row one above
   typedef struct packed {
      logic [PIX_BITS-1:0] older;
      logic [PIX_BITS-1:0] newer;
   } lbp3_line_type;

endpackage

// ===== src/lbp3_line_mem.sv =====
// line store memory: one entry per column holding the two rows above
// depends on lbp3_pkg
module lbp3_line_mem
   import lbp3_pkg::*;
(
   input  logic                clock,
   input  logic                rd_en,
   input  logic [COL_BITS-1:0] rd_addr,
   output lbp3_line_type       rd_data,
   input  logic                wr_en,
   input  logic [COL_BITS-1:0] wr_addr,
   input  lbp3_line_type       wr_data
);

   lbp3_line_type mem [MAX_WIDTH];
   lbp3_line_type rd_data_ff;

   // synchronous read, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lbp3_scan_ctl.sv =====
// raster position counters: column and row of each accepted pixel
// depends on lbp3_pkg
module lbp3_scan_ctl
   import lbp3_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [WIDTH_REG_BITS-1:0]  image_width,
   input  logic [HEIGHT_REG_BITS-1:0] image_height,
   input  logic                       accept,
   input  logic                       frame_start,
   output lbp3_scan_type              scan
);

   localparam logic [WIDTH_REG_BITS-1:0]  W_MIN = WIDTH_REG_BITS'(3);
   localparam logic [WIDTH_REG_BITS-1:0]  W_MAX = WIDTH_REG_BITS'(MAX_WIDTH);
   localparam logic [HEIGHT_REG_BITS-1:0] H_MIN = HEIGHT_REG_BITS'(3);
   localparam logic [HEIGHT_REG_BITS-1:0] H_MAX = HEIGHT_REG_BITS'(HEIGHT_MAX);

   logic [COL_BITS-1:0]        col_ff, col_in, col_cur;
   logic [ROW_BITS-1:0]        row_ff, row_in, row_cur;
   logic [WIDTH_REG_BITS-1:0]  w_eff;
   logic [HEIGHT_REG_BITS-1:0] h_eff;
   logic [WIDTH_REG_BITS-1:0]  col_next;
   logic [HEIGHT_REG_BITS-1:0] row_next;

   // clamp the frame size registers
   always_comb begin
      if (image_width < W_MIN) begin
         w_eff = W_MIN;
      end else if (image_width > W_MAX) begin
         w_eff = W_MAX;
      end else begin
         w_eff = image_width;
      end
      if (image_height < H_MIN) begin
         h_eff = H_MIN;
      end else if (image_height > H_MAX) begin
         h_eff = H_MAX;
      end else begin
         h_eff = image_height;
      end
   end

   // position of the current pixel and the next one
   always_comb begin
      col_cur  = frame_start ? '0 : col_ff;
      row_cur  = frame_start ? '0 : row_ff;
      col_next = WIDTH_REG_BITS'(col_cur) + WIDTH_REG_BITS'(1);
      row_next = HEIGHT_REG_BITS'(row_cur) + HEIGHT_REG_BITS'(1);

      scan.col        = col_cur;
      scan.has_result = (row_cur >= ROW_BITS'(2)) && (col_cur >= COL_BITS'(2));
      scan.last       = (HEIGHT_REG_BITS'(row_cur) == h_eff - HEIGHT_REG_BITS'(1))
                     && (WIDTH_REG_BITS'(col_cur) == w_eff - WIDTH_REG_BITS'(1));

      if (col_next >= w_eff) begin
         col_in = '0;
         row_in = (row_next >= h_eff) ? '0 : row_next[ROW_BITS-1:0];
      end else begin
         col_in = col_next[COL_BITS-1:0];
         row_in = row_cur;
      end
   end

   // counters advance on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== src/lbp3_window.sv =====
// window stage: line store read-modify-write, 3x3 window and code compare
// depends on lbp3_pkg
module lbp3_window
   import lbp3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [PIX_BITS-1:0] pixel_in,
   input  lbp3_scan_type       scan,
   input  lbp3_line_type       rd_data,
   input  logic                out_room,
   output logic                busy,
   output logic                wr_en,
   output logic [COL_BITS-1:0] wr_addr,
   output lbp3_line_type       wr_data,
   output logic                push,
   output lbp3_rsp_type        push_data
);

   logic                s1_valid_ff;
   logic [PIX_BITS-1:0] s1_pix_ff;
   lbp3_scan_type       s1_scan_ff;
   logic                fwd_valid_ff;
   lbp3_line_type       fwd_data_ff;
   logic [PIX_BITS-1:0] win_ff [2][3];
   lbp3_line_type       line_cur;
   logic [PIX_BITS-1:0] top, mid, bot, ctr;
   logic                fire;

   // take the entry from the previous write when it hit the same column
   always_comb begin
      line_cur = fwd_valid_ff ? fwd_data_ff : rd_data;
      top      = line_cur.older;
      mid      = line_cur.newer;
      bot      = s1_pix_ff;
      ctr      = win_ff[1][1];
   end

   // stage completes unless its result has no room
   assign fire    = s1_valid_ff && (!s1_scan_ff.has_result || out_room);
   assign busy    = s1_valid_ff && !fire;
   assign wr_en   = fire;
   assign wr_addr = s1_scan_ff.col;
   assign wr_data = '{older: mid, newer: bot};
   assign push    = fire && s1_scan_ff.has_result;

   // neighbor compare, clockwise from top-left in bit 7
   always_comb begin
      push_data.pattern_code = {
         win_ff[0][0] > ctr,
         win_ff[1][0] > ctr,
         top          > ctr,
         mid          > ctr,
         bot          > ctr,
         win_ff[1][2] > ctr,
         win_ff[0][2] > ctr,
         win_ff[0][1] > ctr
      };
      push_data.frame_last = s1_scan_ff.last;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            fwd_valid_ff <= fire && (wr_addr == scan.col);
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // stage payload and forwarded entry
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= pixel_in;
         s1_scan_ff  <= scan;
         fwd_data_ff <= wr_data;
      end
   end

   // two previous columns of the window
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (fire) begin
         for (int j = 0; j < 3; j++) begin
            win_ff[0][j] <= win_ff[1][j];
         end
         win_ff[1][0] <= top;
         win_ff[1][1] <= mid;
         win_ff[1][2] <= bot;
      end
   end

endmodule

// ===== src/lbp_code_3x3_stream_core.sv =====
// top level of the 3x3 local binary pattern stream core
// depends on lbp3_pkg, lbp3_scan_ctl, lbp3_line_mem and lbp3_window
//
// Usage
//   req_* carries pixels in raster order, one per transfer; frame_start on
//   the first pixel of a frame restarts the row and column counters.
//   rsp_* carries one 8-bit pattern code per interior pixel, so an H by W
//   frame gives (H-2)*(W-2) codes; frame_last marks the bottom-right one.
//   csr_* is an APB-style port: image_width at 0x0, image_height at 0x4.
//   Write it only while the core is idle.
// Timing
//   One pixel per clock sustained while rsp_stall stays low. A code is formed
//   from the transfer of the pixel one row below and one column right of its
//   center, through the line store read, the window stage and the output register.
// Reset
//   Synchronous, active high: counters, window and output valid clear, the
//   size registers return to 640 by 480. The line store is not cleared.
// Stall
//   The output has a two-entry buffer; a code pushed while rsp_stall holds
//   the head goes to the second entry, and req_stall rises the cycle after
//   when the window stage holds another code. The room flag is registered,
//   so even an isolated output stall can hold off an input transfer.
module lbp_code_3x3_stream_core
   import lbp3_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lbp3_req_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lbp3_rsp_type             rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [WIDTH_REG_BITS-1:0]  width_ff;
   logic [HEIGHT_REG_BITS-1:0] height_ff;
   csr_reg_type                csr_sel;
   logic                       accept;
   logic                       busy;
   lbp3_scan_type              scan;
   lbp3_line_type              rd_data, wr_data;
   logic                       wr_en;
   logic [COL_BITS-1:0]        wr_addr;
   logic                       push;
   lbp3_rsp_type               push_data;
   logic                       head_valid_ff, skid_valid_ff;
   lbp3_rsp_type               head_ff, skid_ff;
   logic                       pop;

   // register port
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      case (csr_sel)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_BITS'(WIDTH_RESET);
         height_ff <= HEIGHT_REG_BITS'(HEIGHT_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_sel)
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[WIDTH_REG_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[HEIGHT_REG_BITS-1:0];
            default:          ;
         endcase
      end
   end

   // input transfer
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   lbp3_scan_ctl u_scan (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .accept       (accept),
      .frame_start  (req_data.frame_start),
      .scan         (scan)
   );

   lbp3_line_mem u_line (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (scan.col),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lbp3_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel_in  (req_data.pixel_value),
      .scan      (scan),
      .rd_data   (rd_data),
      .out_room  (!skid_valid_ff),
      .busy      (busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_data (push_data)
   );

   // two-entry output buffer
   assign pop       = head_valid_ff && !rsp_stall;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_valid_ff <= 1'b1;
            skid_valid_ff <= push;
         end else begin
            head_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
            skid_ff <= push_data;
         end else begin
            head_ff <= push_data;
         end
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

endmodule

// ===== src/lbp3_checker.sv =====
// port-level checks for the 3x3 local binary pattern stream core
// depends on lbp3_pkg; bound to lbp_code_3x3_stream_core
module lbp3_checker
   import lbp3_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input lbp3_rsp_type rsp_data
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input backpressure only once a result is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

   // reset leaves the core empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("core not empty after reset");

   // a fresh result follows an earlier input transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without matching input transfer");

endmodule

bind lbp_code_3x3_stream_core lbp3_checker u_lbp3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
